// File: design/bba_pkg.sv
// Shared types, constants and helper functions for the bitmap block allocator.
// Used by the map RAM, the register block, the controller and the top level.
package bba_pkg;

  localparam int unsigned MAX_BLOCKS    = 65536;
  localparam int unsigned MAP_WORD_BITS = 32;
  localparam int unsigned MAP_DEPTH     = MAX_BLOCKS / MAP_WORD_BITS;
  localparam int unsigned WORD_IDX_W    = $clog2(MAP_DEPTH);
  localparam int unsigned BIT_IDX_W     = $clog2(MAP_WORD_BITS);
  localparam int unsigned SCAN_W        = WORD_IDX_W + 1;
  localparam int unsigned BLK_W         = 16;
  localparam int unsigned TOTAL_W       = 17;
  localparam int unsigned TOTAL_RESET   = 65536;

  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;
  localparam int unsigned IN_TDATA_W    = 24;
  localparam int unsigned OUT_TDATA_W   = 40;

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_READ    = 2'd2,
    KIND_WRITE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  // Register select bit of paddr (register i lies at byte address 4*i).
  localparam logic REG_TOTAL_BLOCKS = 1'b0;

  typedef struct packed {
    logic                  rd_en;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [WORD_IDX_W-1:0] wr_addr;
    map_word_t             wr_data;
  } map_req_t;

  typedef struct packed {
    status_e            status;
    logic [BLK_W-1:0]   block;
    logic               read_value;
    logic [TOTAL_W-1:0] free_count;
  } res_t;

  // Index of the lowest clear bit of a map word.
  function automatic logic [BIT_IDX_W-1:0] first_zero(input map_word_t word);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: design/bba_map_ram.sv
// Single-port-write, single-port-read synchronous RAM holding the usage bitmap.
// Depends on bba_pkg for depth, word width and the request struct.
module bba_map_ram (
  input  logic              clk_i,
  input  bba_pkg::map_req_t req_i,
  output bba_pkg::map_word_t rd_data_o
);

  bba_pkg::map_word_t mem [bba_pkg::MAP_DEPTH];
  bba_pkg::map_word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/bba_regs.sv
// APB-style configuration register block holding total_blocks.
// Depends on bba_pkg for widths and the register select code.
module bba_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bba_pkg::PADDR_W-1:0] paddr,
  input  logic [bba_pkg::PDATA_W-1:0] pwdata,
  output logic [bba_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [bba_pkg::TOTAL_W-1:0] eff_total_o
);

  logic [bba_pkg::TOTAL_W-1:0] total_q, total_d;
  logic                        sel_total;

  assign pready    = 1'b1;
  assign sel_total = (paddr[2] == bba_pkg::REG_TOTAL_BLOCKS);

  always_comb begin
    total_d = total_q;
    if (psel && penable && pwrite && pready && sel_total) begin
      total_d = pwdata[bba_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= bba_pkg::TOTAL_W'(bba_pkg::TOTAL_RESET);
    end else begin
      total_q <= total_d;
    end
  end

  assign prdata = sel_total ? bba_pkg::PDATA_W'(total_q) : '0;

  assign eff_total_o = (total_q > bba_pkg::TOTAL_W'(bba_pkg::MAX_BLOCKS)) ?
                       bba_pkg::TOTAL_W'(bba_pkg::MAX_BLOCKS) : total_q;

endmodule

// File: design/bba_ctrl.sv
// Sequencer for the allocator: clearing pass, read-modify-write of map words,
// first-fit scan and used-block count. Depends on bba_pkg.
module bba_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bba_pkg::kind_e              in_kind_i,
  input  logic [bba_pkg::BLK_W-1:0]   in_block_i,
  input  logic                        in_bit_i,
  input  logic [bba_pkg::TOTAL_W-1:0] total_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output bba_pkg::res_t               res_o,
  output bba_pkg::map_req_t           map_req_o,
  input  bba_pkg::map_word_t          map_rd_data_i
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  localparam int unsigned WIW = bba_pkg::WORD_IDX_W;
  localparam int unsigned BIW = bba_pkg::BIT_IDX_W;
  localparam int unsigned SW  = bba_pkg::SCAN_W;
  localparam int unsigned TW  = bba_pkg::TOTAL_W;

  state_e                      state_q, state_d;
  bba_pkg::kind_e              kind_q, kind_d;
  logic [bba_pkg::BLK_W-1:0]   blk_q, blk_d;
  logic                        bitv_q, bitv_d;
  logic [SW-1:0]               scan_q, scan_d;
  logic [SW-1:0]               hint_q, hint_d;
  logic [TW-1:0]               used_q, used_d;
  logic [WIW-1:0]              clr_q, clr_d;
  bba_pkg::status_e            status_q, status_d;
  logic [bba_pkg::BLK_W-1:0]   rblk_q, rblk_d;
  logic                        rd_q, rd_d;

  logic [BIW-1:0]              bit_sel;
  bba_pkg::map_word_t          mask;
  logic [WIW-1:0]              blk_word;
  logic [SW-1:0]               scan_next;
  logic [BIW-1:0]              zero_idx;
  logic [bba_pkg::BLK_W-1:0]   found;

  assign bit_sel   = blk_q[BIW-1:0];
  assign blk_word  = blk_q[bba_pkg::BLK_W-1:BIW];
  assign mask      = bba_pkg::map_word_t'(1) << bit_sel;
  assign scan_next = scan_q + SW'(1);
  assign zero_idx  = bba_pkg::first_zero(map_rd_data_i);
  assign found     = {scan_q[WIW-1:0], zero_idx};

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.status     = status_q;
    res_o.block      = rblk_q;
    res_o.read_value = rd_q;
    res_o.free_count = (used_q <= total_i) ? (total_i - used_q) : '0;
  end

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    blk_d     = blk_q;
    bitv_d    = bitv_q;
    scan_d    = scan_q;
    hint_d    = hint_q;
    used_d    = used_q;
    clr_d     = clr_q;
    status_d  = status_q;
    rblk_d    = rblk_q;
    rd_d      = rd_q;
    map_req_o = '0;

    case (state_q)
      S_CLEAR: begin
        map_req_o.wr_en   = 1'b1;
        map_req_o.wr_addr = clr_q;
        map_req_o.wr_data = '0;
        clr_d             = clr_q + WIW'(1);
        if (clr_q == WIW'(bba_pkg::MAP_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d   = in_kind_i;
          blk_d    = in_block_i;
          bitv_d   = in_bit_i;
          status_d = bba_pkg::STATUS_OK;
          rblk_d   = in_block_i;
          rd_d     = 1'b0;
          if (in_kind_i == bba_pkg::KIND_ALLOC) begin
            if ((used_q >= total_i) || ({hint_q, BIW'(0)} >= total_i)) begin
              status_d = bba_pkg::STATUS_FULL;
              rblk_d   = '0;
              state_d  = S_DONE;
            end else begin
              map_req_o.rd_en   = 1'b1;
              map_req_o.rd_addr = hint_q[WIW-1:0];
              scan_d            = hint_q;
              state_d           = S_EVAL;
            end
          end else if (TW'(in_block_i) >= total_i) begin
            status_d = bba_pkg::STATUS_RANGE;
            state_d  = S_DONE;
          end else begin
            map_req_o.rd_en   = 1'b1;
            map_req_o.rd_addr = in_block_i[bba_pkg::BLK_W-1:BIW];
            state_d           = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        case (kind_q)
          bba_pkg::KIND_ALLOC: begin
            if (map_rd_data_i != '1) begin
              hint_d  = scan_q;
              state_d = S_DONE;
              if (TW'(found) >= total_i) begin
                status_d = bba_pkg::STATUS_FULL;
                rblk_d   = '0;
              end else begin
                map_req_o.wr_en   = 1'b1;
                map_req_o.wr_addr = scan_q[WIW-1:0];
                map_req_o.wr_data = map_rd_data_i |
                                    (bba_pkg::map_word_t'(1) << zero_idx);
                used_d            = used_q + TW'(1);
                rblk_d            = found;
              end
            end else begin
              hint_d = scan_next;
              if ({scan_next, BIW'(0)} >= total_i) begin
                status_d = bba_pkg::STATUS_FULL;
                rblk_d   = '0;
                state_d  = S_DONE;
              end else begin
                map_req_o.rd_en   = 1'b1;
                map_req_o.rd_addr = scan_next[WIW-1:0];
                scan_d            = scan_next;
              end
            end
          end
          bba_pkg::KIND_RELEASE: begin
            map_req_o.wr_en   = 1'b1;
            map_req_o.wr_addr = blk_word;
            map_req_o.wr_data = map_rd_data_i & ~mask;
            used_d            = (used_q != '0) ? (used_q - TW'(1)) : '0;
            if ({1'b0, blk_word} < hint_q) begin
              hint_d = {1'b0, blk_word};
            end
            state_d = S_DONE;
          end
          bba_pkg::KIND_READ: begin
            rd_d    = map_rd_data_i[bit_sel];
            state_d = S_DONE;
          end
          bba_pkg::KIND_WRITE: begin
            map_req_o.wr_en   = 1'b1;
            map_req_o.wr_addr = blk_word;
            map_req_o.wr_data = bitv_q ? (map_rd_data_i | mask) : (map_rd_data_i & ~mask);
            if (!bitv_q && ({1'b0, blk_word} < hint_q)) begin
              hint_d = {1'b0, blk_word};
            end
            state_d = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      used_q  <= '0;
      hint_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
      hint_q  <= hint_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    blk_q    <= blk_d;
    bitv_q   <= bitv_d;
    scan_q   <= scan_d;
    status_q <= status_d;
    rblk_q   <= rblk_d;
    rd_q     <= rd_d;
  end

  a_no_rw_same_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(map_req_o.rd_en && map_req_o.wr_en && (map_req_o.rd_addr == map_req_o.wr_addr)))
    else $error("map word read and written in the same cycle");

  a_used_dec_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q < $past(used_q)) |-> ($past(state_q) == S_EVAL && $past(kind_q) == bba_pkg::KIND_RELEASE))
    else $error("used count fell without a release");

  a_used_inc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && used_d > used_q) |-> (used_d == used_q + TW'(1) && map_req_o.wr_en))
    else $error("used count grew without a map write");

  a_hint_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= SW'(bba_pkg::MAP_DEPTH))
    else $error("scan start beyond map depth");

endmodule

// File: design/bitmap_block_allocator_unit.sv
// Bitmap block allocator: first-fit allocation over a free-space bitmap in RAM.
// Depends on bba_pkg, bba_regs, bba_ctrl and bba_map_ram.
//
// Items arrive on the s_axis channel (kind, block number, bit value) and one
// result item per input leaves on m_axis (status, block, read bit, free count).
// total_blocks is set through the APB-style port at byte address 0; the user
// must write it only while no item is in flight; the block does not enforce it.
// After reset all 2048 bitmap RAM words are cleared one word per cycle, and
// s_axis_tready stays low until the pass ends; configuration writes are taken.
// Release, read bit and write bit go from acceptance to result through the RAM
// read, then the evaluate and write-back state, then the result state.
// Allocate reads map words in turn, from the lowest word that may still hold a
// free block, until one has a clear bit or the scan passes total_blocks; the
// scan start means that usually only one word is read. An item refused at
// acceptance (a block number out of range, or an allocate refused by the used
// count or the scan start) goes straight to the result state. One item is
// taken at a time; the next waits until the previous result moves on.
// The result sits in an output register; the next item is accepted while it
// waits. A stalled receiver holds the result, and the block holds the next
// result internally until the output register frees.
module bitmap_block_allocator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] kind, [17:2] block_number, [18] bit_value, [23:19] zero
  input  logic [bba_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] status, [17:2] result_block, [18] read_value, [35:19] free_count,
  // [39:36] zero
  output logic [bba_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bba_pkg::PADDR_W-1:0]     paddr,
  input  logic [bba_pkg::PDATA_W-1:0]     pwdata,
  output logic [bba_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  logic [bba_pkg::TOTAL_W-1:0] eff_total;
  logic                        res_valid;
  logic                        res_ready;
  bba_pkg::res_t               res;
  bba_pkg::map_req_t           map_req;
  bba_pkg::map_word_t          map_rd_data;
  logic                        out_valid_q, out_valid_d;
  bba_pkg::res_t               out_q, out_d;

  bba_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .eff_total_o (eff_total)
  );

  bba_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_kind_i     (bba_pkg::kind_e'(s_axis_tdata[1:0])),
    .in_block_i    (s_axis_tdata[17:2]),
    .in_bit_i      (s_axis_tdata[18]),
    .total_i       (eff_total),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .map_req_o     (map_req),
    .map_rd_data_i (map_rd_data)
  );

  bba_map_ram u_map (
    .clk_i     (clk_i),
    .req_i     (map_req),
    .rd_data_o (map_rd_data)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q.free_count, out_q.read_value, out_q.block,
                          out_q.status};

endmodule

// File: sim/tb_bitmap_block_allocator_unit.sv
// Self-checking testbench for the bitmap block allocator unit.
// Depends on bba_pkg and bitmap_block_allocator_unit; it drives s_axis and APB
// and checks every m_axis item against a first-fit bitmap predictor.
`timescale 1ns / 100ps

class alloc_scoreboard;
  bba_pkg::map_word_t usage_words [bba_pkg::MAP_DEPTH];
  int unsigned        used_blocks;
  int unsigned        total_blocks;
  bba_pkg::res_t      expected_q[$];
  int unsigned        errors;

  function new();
    foreach (usage_words[w]) usage_words[w] = '0;
    used_blocks  = 0;
    total_blocks = bba_pkg::TOTAL_RESET;
    errors       = 0;
  endfunction

  function void set_total(logic [bba_pkg::TOTAL_W-1:0] value);
    total_blocks = value;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function int lowest_clear();
    for (int w = 0; w < bba_pkg::MAP_DEPTH; w++) begin
      if (usage_words[w] != '1) begin
        for (int b = 0; b < bba_pkg::MAP_WORD_BITS; b++) begin
          if (!usage_words[w][b]) return w * bba_pkg::MAP_WORD_BITS + b;
        end
      end
    end
    return -1;
  endfunction

  function void note_item(bba_pkg::kind_e kind, logic [bba_pkg::BLK_W-1:0] blk,
                          logic bit_value);
    int unsigned   limit;
    int unsigned   word_idx;
    int unsigned   bit_idx;
    int            first_free;
    bba_pkg::res_t res;
    limit          = (total_blocks < bba_pkg::MAX_BLOCKS) ? total_blocks : bba_pkg::MAX_BLOCKS;
    word_idx       = blk / bba_pkg::MAP_WORD_BITS;
    bit_idx        = blk % bba_pkg::MAP_WORD_BITS;
    res.status     = bba_pkg::STATUS_OK;
    res.block      = blk;
    res.read_value = 1'b0;
    if (kind == bba_pkg::KIND_ALLOC) begin
      first_free = lowest_clear();
      if (used_blocks >= limit || first_free < 0 || first_free >= int'(limit)) begin
        res.status = bba_pkg::STATUS_FULL;
        res.block  = '0;
      end else begin
        usage_words[first_free / bba_pkg::MAP_WORD_BITS][first_free % bba_pkg::MAP_WORD_BITS]
          = 1'b1;
        used_blocks++;
        res.block = first_free[bba_pkg::BLK_W-1:0];
      end
    end else if (blk >= limit) begin
      res.status = bba_pkg::STATUS_RANGE;
    end else begin
      case (kind)
        bba_pkg::KIND_RELEASE: begin
          usage_words[word_idx][bit_idx] = 1'b0;
          if (used_blocks > 0) used_blocks--;
        end
        bba_pkg::KIND_READ: begin
          res.read_value = usage_words[word_idx][bit_idx];
        end
        default: begin
          usage_words[word_idx][bit_idx] = bit_value;
        end
      endcase
    end
    res.free_count = (used_blocks <= limit) ? bba_pkg::TOTAL_W'(limit - used_blocks) : '0;
    expected_q.push_back(res);
  endfunction

  function void check_result(logic [bba_pkg::OUT_TDATA_W-1:0] data);
    bba_pkg::res_t res;
    if (expected_q.size() == 0) begin
      $error("result item with no expectation waiting: tdata %h", data);
      errors++;
      return;
    end
    res = expected_q.pop_front();
    if (data[1:0] !== res.status) begin
      $error("status: expected %0d, actual %0d", res.status, data[1:0]);
      errors++;
    end
    if (data[17:2] !== res.block) begin
      $error("result_block: expected %0d, actual %0d", res.block, data[17:2]);
      errors++;
    end
    if (data[18] !== res.read_value) begin
      $error("read_value: expected %0d, actual %0d", res.read_value, data[18]);
      errors++;
    end
    if (data[35:19] !== res.free_count) begin
      $error("free_count: expected %0d, actual %0d", res.free_count, data[35:19]);
      errors++;
    end
  endfunction
endclass

module tb_bitmap_block_allocator_unit;
  import bba_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  localparam logic [PADDR_W-1:0] ADDR_TOTAL_BLOCKS = '0;
  localparam int unsigned        HOLD_OFF_CYCLES   = 400;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [PADDR_W-1:0]     paddr         = '0;
  logic [PDATA_W-1:0]     pwdata        = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  alloc_scoreboard sb = new();

  int unsigned tx_idle_pct   = 0;
  int unsigned rx_stall_pct  = 0;
  bit          hold_request  = 1'b0;
  int unsigned rx_hold_left  = 0;

  bitmap_block_allocator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
    if (hold_request) begin
      hold_request = 1'b0;
      rx_hold_left = HOLD_OFF_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic set_idle_mode(input idle_mode_e mode);
    tx_idle_pct  = (mode == IDLE_SENDER || mode == IDLE_RECEIVER) ? 0 : 0;
    rx_stall_pct = 0;
    case (mode)
      IDLE_SENDER: begin
        tx_idle_pct = 88;
      end
      IDLE_RECEIVER: begin
        rx_stall_pct = 88;
      end
      IDLE_BOTH: begin
        tx_idle_pct  = 7;
        rx_stall_pct = 7;
      end
      default: begin
      end
    endcase
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_item(input kind_e kind, input logic [BLK_W-1:0] blk,
                           input logic bit_value);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, bit_value, blk, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(kind, blk, bit_value);
  endtask

  // The block is written only after every outstanding result has been taken.
  task automatic set_total_blocks(input logic [TOTAL_W-1:0] value);
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TOTAL_BLOCKS;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_total(value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[TOTAL_W-1:0] !== value) begin
      $error("total_blocks: expected %0d, actual %0d", value, prdata[TOTAL_W-1:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [TOTAL_W-1:0] total, input int unsigned count,
                           input idle_mode_e mode, input int unsigned span);
    int unsigned        limit;
    int unsigned        pick;
    kind_e              kind;
    logic [BLK_W-1:0]   blk;
    set_total_blocks(total);
    set_idle_mode(mode);
    limit = (total < MAX_BLOCKS) ? total : MAX_BLOCKS;
    repeat (count) begin
      pick = $urandom_range(99);
      kind = (pick < 40) ? KIND_ALLOC : (pick < 70) ? KIND_RELEASE :
             (pick < 85) ? KIND_READ : KIND_WRITE;
      pick = $urandom_range(99);
      if (pick < 70) begin
        blk = BLK_W'($urandom_range(span, 0));
      end else if (pick < 85) begin
        blk = BLK_W'(limit + $urandom_range(3) - 2);
      end else begin
        blk = BLK_W'($urandom);
      end
      send_item(kind, blk, 1'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(KIND_ALLOC, 16'd0, 1'b0);
    send_item(KIND_ALLOC, 16'hFFFF, 1'b1);
    send_item(KIND_READ, 16'd0, 1'b0);
    send_item(KIND_READ, 16'hFFFF, 1'b1);
    send_item(KIND_WRITE, 16'hFFFF, 1'b1);
    send_item(KIND_READ, 16'hFFFF, 1'b0);
    send_item(KIND_WRITE, 16'hFFFF, 1'b0);
    send_item(KIND_RELEASE, 16'd0, 1'b0);
    send_item(KIND_ALLOC, 16'd0, 1'b0);
    send_item(KIND_RELEASE, 16'd100, 1'b0);
    send_item(KIND_RELEASE, 16'd101, 1'b0);
    send_item(KIND_RELEASE, 16'd102, 1'b0);
    send_item(KIND_RELEASE, 16'd103, 1'b0);
    send_item(KIND_WRITE, 16'd2, 1'b1);
    send_item(KIND_ALLOC, 16'd0, 1'b0);
    set_total_blocks(17'd0);
    send_item(KIND_ALLOC, 16'd0, 1'b0);
    send_item(KIND_READ, 16'd0, 1'b0);
    set_total_blocks(17'h1FFFF);
    send_item(KIND_READ, 16'hFFFF, 1'b0);
    set_total_blocks(17'd2);
    send_item(KIND_ALLOC, 16'd0, 1'b0);
    send_item(KIND_RELEASE, 16'd1, 1'b0);
    send_item(KIND_ALLOC, 16'd0, 1'b0);
    set_total_blocks(17'd1);
    send_item(KIND_ALLOC, 16'd0, 1'b0);
    send_item(KIND_READ, 16'd1, 1'b0);
    send_item(KIND_WRITE, 16'd0, 1'b1);

    // Drain first so that the long receiver hold overlaps a busy sender.
    set_total_blocks(17'd48);
    hold_request = 1'b1;
    run_phase(17'd48, 250, IDLE_NONE, 60);
    run_phase(17'd65536, 200, IDLE_SENDER, 80);
    run_phase(17'd1, 100, IDLE_RECEIVER, 3);
    run_phase(17'h1FFFF, 150, IDLE_BOTH, 120);
    run_phase(17'd20, 200, IDLE_NONE, 30);
    run_phase(17'd0, 50, IDLE_SENDER, 4);
    run_phase(17'd33, 250, IDLE_RECEIVER, 40);
    run_phase(17'd64, 150, IDLE_BOTH, 70);

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS bitmap_block_allocator_unit");
    end else begin
      $display("FAIL bitmap_block_allocator_unit");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL bitmap_block_allocator_unit");
    $finish;
  end

endmodule
